[design/assert_macros.svh]
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/pscr_pkg.sv]
package pscr_pkg;

    localparam int CURRENT_ADC_BITS = 16;
    localparam int CUR_W = 17;
    localparam int CMP_W = (CURRENT_ADC_BITS + 1 > CUR_W) ? CURRENT_ADC_BITS + 1 : CUR_W;
    localparam logic [CMP_W-1:0] FULL_SCALE = CMP_W'(1) << CURRENT_ADC_BITS;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_SETPOINT = 3'd1,
        CMD_POLARITY = 3'd2,
        CMD_START    = 3'd3,
        CMD_ON       = 3'd4,
        CMD_STANDBY  = 3'd5,
        CMD_SHUTDOWN = 3'd6,
        CMD_READ     = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_UNKNOWN = 2'd0,
        MODE_STANDBY = 2'd1,
        MODE_ON      = 2'd2,
        MODE_OFF     = 2'd3
    } t_mode;

    typedef enum logic {
        REG_STEP_UP   = 1'b0,
        REG_STEP_DOWN = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_cmd              cmd;
        logic [CUR_W-1:0]  setpoint;
        logic signed [1:0] polarity;
    } t_item;

    typedef struct packed {
        logic              status;
        logic [CUR_W-1:0]  current;
        logic [CUR_W-1:0]  setpoint;
        logic signed [1:0] polarity;
        t_mode             mode;
        logic              ramp_active;
    } t_result;

endpackage

[design/pscr_core.sv]
module pscr_core import pscr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_item            i_item,
    input  logic [CUR_W-1:0] i_step_up,
    input  logic [CUR_W-1:0] i_step_down,
    output t_result          o_result
);

    logic [CUR_W-1:0]  r_current, n_current;
    logic [CUR_W-1:0]  r_target, n_target;
    logic signed [1:0] r_polarity, n_polarity;
    t_mode             r_mode, n_mode;
    logic              r_armed, n_armed;
    logic              w_status;

    logic [CUR_W-1:0]  w_dist_up, w_dist_dn, w_inc, w_dec;
    logic [CMP_W-1:0]  w_sp_ext;

    assign w_dist_up = r_target - r_current;
    assign w_dist_dn = r_current - r_target;
    assign w_inc     = (w_dist_up < i_step_up) ? w_dist_up : i_step_up;
    assign w_dec     = (w_dist_dn < i_step_down) ? w_dist_dn : i_step_down;
    assign w_sp_ext  = CMP_W'(i_item.setpoint);

    always_comb begin
        n_current  = r_current;
        n_target   = r_target;
        n_polarity = r_polarity;
        n_mode     = r_mode;
        n_armed    = r_armed;
        w_status   = 1'b0;
        case (i_item.cmd)
            CMD_TICK: begin
                if (r_armed && r_mode == MODE_ON) begin
                    if (r_target > r_current) begin
                        n_current = r_current + w_inc;
                    end else if (r_target < r_current) begin
                        n_current = r_current - w_dec;
                    end else begin
                        n_armed = 1'b0;
                    end
                end
            end
            CMD_SETPOINT: begin
                if (w_sp_ext > FULL_SCALE) begin
                    w_status = 1'b1;
                end else begin
                    n_target = i_item.setpoint;
                end
            end
            CMD_POLARITY: n_polarity = i_item.polarity;
            CMD_START:    n_armed    = 1'b1;
            CMD_ON:       n_mode     = MODE_ON;
            CMD_STANDBY:  n_mode     = MODE_STANDBY;
            CMD_SHUTDOWN: n_mode     = MODE_OFF;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current  <= '0;
            r_target   <= '0;
            r_polarity <= '0;
            r_mode     <= MODE_STANDBY;
            r_armed    <= 1'b0;
        end else if (i_en) begin
            r_current  <= n_current;
            r_target   <= n_target;
            r_polarity <= n_polarity;
            r_mode     <= n_mode;
            r_armed    <= n_armed;
        end
    end

    // result fields reflect the state after this item is applied; status flags a rejected setpoint
    always_comb begin
        o_result.status      = w_status;
        o_result.current     = (n_polarity == 2'sd0) ? '0 : n_current;
        o_result.setpoint    = n_target;
        o_result.polarity    = n_polarity;
        o_result.mode        = n_mode;
        o_result.ramp_active = n_armed;
    end

endmodule

[design/power_supply_current_ramp_top.sv]
// An accepted result goes to the output register, or to the skid entry while that is held.
// One item per cycle while the skid entry is empty; the state update is a single registered step.
// Output register plus one skid entry; tready drops only while the skid entry is full.
// Reset (synchronous, active low): current, setpoint, polarity 0, mode standby, ramp disarmed,
// both step registers 1, output side empty.
module power_supply_current_ramp_top import pscr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // command[2:0], setpoint_code[19:3], polarity_value[21:20], zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // status[0], current_readout[17:1], setpoint_readout[34:18],
    // polarity_readout[36:35], mode_readout[38:37], ramp_active[39]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [CUR_W-1:0]       i_cfg_data
);

    `include "assert_macros.svh"

    logic [CUR_W-1:0] r_step_up, r_step_down;
    t_item            w_item;
    t_result          w_result;
    t_result          r_out, r_skid;
    logic             r_out_valid, r_skid_valid;
    logic             w_accept, w_pop;

    assign w_item.cmd      = t_cmd'(i_s_axis_tdata[2:0]);
    assign w_item.setpoint = i_s_axis_tdata[19:3];
    assign w_item.polarity = i_s_axis_tdata[21:20];

    assign o_s_axis_tready = !r_skid_valid;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pop           = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_up   <= CUR_W'(1);
            r_step_down <= CUR_W'(1);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_STEP_UP:   r_step_up   <= i_cfg_data;
                REG_STEP_DOWN: r_step_down <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pscr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_accept),
        .i_item      (w_item),
        .i_step_up   (r_step_up),
        .i_step_down (r_step_down),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (w_pop) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (w_accept) begin
                if (!r_out_valid || w_pop) begin
                    r_out       <= w_result;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= w_result;
                    r_skid_valid <= 1'b1;
                end
            end else if (w_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.ramp_active, r_out.mode, r_out.polarity,
                              r_out.setpoint, r_out.current, r_out.status};

    `ASSERT_CLKD(a_skid_needs_out, r_skid_valid |-> r_out_valid, "skid full with output empty")
    `ASSERT_CLKD(a_zero_pol_zero_cur,
        (r_out_valid && r_out.polarity == 2'sd0) |-> (r_out.current == '0),
        "current shown with polarity zero")
    `ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!r_out_valid && !r_skid_valid),
        "output side not empty after reset")

endmodule

[tb/tb_power_supply_current_ramp_top.sv]
module tb_power_supply_current_ramp_top;
    import pscr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic              status;
        logic [CUR_W-1:0]  current;
        logic [CUR_W-1:0]  setpoint;
        logic [1:0]        polarity;
        t_mode             mode;
        logic              armed;
    } t_readback;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic                   i_cfg_addr = 1'b0;
    logic [CUR_W-1:0]       i_cfg_data = '0;

    power_supply_current_ramp_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    // regulator state as predicted
    logic [CUR_W-1:0] pred_current;
    logic [CUR_W-1:0] pred_target;
    logic [1:0]       pred_pol;
    t_mode            pred_mode;
    logic             pred_armed;
    logic [CUR_W-1:0] step_up;
    logic [CUR_W-1:0] step_down;

    t_readback expected_readbacks[$];

    bit src_idle;
    bit sink_idle;
    int n_sent;
    int n_checked;
    int n_errors;
    int n_ramps_done;
    int n_step_settings;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_readback apply_command(t_cmd c, logic [CUR_W-1:0] sp, logic [1:0] pol);
        t_readback r;
        logic [CUR_W-1:0] span;
        r.status = 1'b0;
        case (c)
            CMD_TICK: begin
                if (pred_armed && pred_mode == MODE_ON) begin
                    if (pred_target > pred_current) begin
                        span = pred_target - pred_current;
                        pred_current += (span < step_up) ? span : step_up;
                    end else if (pred_target < pred_current) begin
                        span = pred_current - pred_target;
                        pred_current -= (span < step_down) ? span : step_down;
                    end else begin
                        pred_armed = 1'b0;
                        n_ramps_done++;
                    end
                end
            end
            CMD_SETPOINT: begin
                if (sp > FULL_SCALE) r.status = 1'b1;
                else pred_target = sp;
            end
            CMD_POLARITY: pred_pol = pol;
            CMD_START:    pred_armed = 1'b1;
            CMD_ON:       pred_mode = MODE_ON;
            CMD_STANDBY:  pred_mode = MODE_STANDBY;
            CMD_SHUTDOWN: pred_mode = MODE_OFF;
            default: ;
        endcase
        r.current  = (pred_pol == 2'b00) ? '0 : pred_current;
        r.setpoint = pred_target;
        r.polarity = pred_pol;
        r.mode     = pred_mode;
        r.armed    = pred_armed;
        return r;
    endfunction

    task automatic send_item(t_cmd c, logic [CUR_W-1:0] sp, logic [1:0] pol);
        int gap;
        gap = src_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, pol, sp, c};
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_readbacks.push_back(apply_command(c, sp, pol));
        n_sent++;
    endtask

    // command whose payload fields are don't-care
    task automatic send_plain(t_cmd c);
        send_item(c, CUR_W'($urandom), 2'($urandom));
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_readbacks.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CUR_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_STEP_UP) step_up = val;
        else step_down = val;
    endtask

    task automatic set_steps(logic [CUR_W-1:0] up, logic [CUR_W-1:0] down);
        wait_idle();
        write_reg(REG_STEP_UP, up);
        write_reg(REG_STEP_DOWN, down);
        n_step_settings++;
    endtask

    initial begin : sink
        int stall;
        wait (i_rst_n);
        forever begin
            stall = sink_idle ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_readback want;
        t_readback got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.status   = o_m_axis_tdata[0];
            got.current  = o_m_axis_tdata[17:1];
            got.setpoint = o_m_axis_tdata[34:18];
            got.polarity = o_m_axis_tdata[36:35];
            got.mode     = t_mode'(o_m_axis_tdata[38:37]);
            got.armed    = o_m_axis_tdata[39];
            if (expected_readbacks.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("%t: unexpected result %h", $realtime, o_m_axis_tdata);
            end else begin
                want = expected_readbacks.pop_front();
                n_checked++;
                if (got.status !== want.status || got.current !== want.current ||
                    got.setpoint !== want.setpoint || got.polarity !== want.polarity ||
                    got.mode !== want.mode || got.armed !== want.armed) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("%t: mismatch exp st=%0b cur=%0d sp=%0d pol=%0d mode=%0d arm=%0b",
                                 $realtime, want.status, want.current, want.setpoint,
                                 want.polarity, want.mode, want.armed);
                        $display("    got st=%0b cur=%0d sp=%0d pol=%0d mode=%0d arm=%0b",
                                 got.status, got.current, got.setpoint, got.polarity,
                                 got.mode, got.armed);
                    end
                end
            end
        end
    end

    task automatic test_directed_commands();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        send_plain(CMD_READ);
        send_item(CMD_SETPOINT, 17'h1FFFF, 2'($urandom));    // rejected
        send_item(CMD_SETPOINT, 17'd65537, 2'($urandom));    // just above full scale
        send_item(CMD_SETPOINT, 17'd65536, 2'($urandom));    // full scale accepted
        send_item(CMD_SETPOINT, 17'd4, 2'($urandom));
        send_plain(CMD_START);
        send_plain(CMD_TICK);                                 // standby: no motion
        send_plain(CMD_ON);
        send_plain(CMD_TICK);                                 // polarity 0 hides current
        send_item(CMD_POLARITY, CUR_W'($urandom), 2'b10);     // -2 pattern
        send_plain(CMD_TICK);
        send_item(CMD_POLARITY, CUR_W'($urandom), 2'b01);
        send_plain(CMD_TICK);
        send_item(CMD_POLARITY, CUR_W'($urandom), 2'b11);
        send_plain(CMD_TICK);
        send_plain(CMD_TICK);                                 // at target: disarms
        send_plain(CMD_TICK);
        send_item(CMD_SETPOINT, 17'd0, 2'($urandom));
        send_plain(CMD_START);
        send_plain(CMD_SHUTDOWN);
        send_plain(CMD_TICK);                                 // off: no motion
        send_plain(CMD_STANDBY);
        send_plain(CMD_ON);
        send_plain(CMD_TICK);
        send_item(CMD_POLARITY, CUR_W'($urandom), 2'b00);
        send_plain(CMD_READ);
    endtask

    task automatic test_step_extremes();
        set_steps('0, '0);
        send_item(CMD_SETPOINT, 17'd100, 2'($urandom));
        send_item(CMD_POLARITY, CUR_W'($urandom), 2'b01);
        send_plain(CMD_START);
        send_plain(CMD_ON);
        repeat (3) send_plain(CMD_TICK);                      // zero step: stays armed
        set_steps(17'h1FFFF, 17'd65536);
        send_plain(CMD_TICK);
        send_plain(CMD_TICK);
        send_item(CMD_SETPOINT, 17'd65536, 2'($urandom));
        send_plain(CMD_START);
        send_plain(CMD_TICK);
        send_item(CMD_SETPOINT, 17'd0, 2'($urandom));
        send_plain(CMD_START);
        send_plain(CMD_TICK);
        send_plain(CMD_TICK);
        set_steps(17'd65536, 17'h1FFFF);
        send_item(CMD_SETPOINT, 17'd65536, 2'($urandom));
        send_plain(CMD_START);
        send_plain(CMD_TICK);
        send_item(CMD_SETPOINT, 17'd7, 2'($urandom));
        send_plain(CMD_START);
        send_plain(CMD_TICK);
        send_plain(CMD_TICK);
    endtask

    task automatic test_random_traffic(int n_phases, int per_phase);
        int r;
        int near;
        t_cmd c;
        logic [CUR_W-1:0] sp;
        for (int ph = 0; ph < n_phases; ph++) begin
            case ($urandom_range(0, 4))
                0: set_steps(CUR_W'($urandom_range(1, 16)), CUR_W'($urandom_range(1, 16)));
                1: set_steps(CUR_W'($urandom_range(0, 4096)), CUR_W'($urandom_range(0, 4096)));
                2: set_steps(CUR_W'($urandom), CUR_W'($urandom));
                3: set_steps('0, CUR_W'($urandom_range(1, 64)));
                default: set_steps(17'd1, 17'd1);
            endcase
            // first phase runs without any idling
            src_idle  = (ph != 0) && ($urandom_range(0, 3) != 0);
            sink_idle = (ph != 0) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < per_phase; k++) begin
                r = $urandom_range(0, 99);
                if (r < 40)      c = CMD_TICK;
                else if (r < 55) c = CMD_SETPOINT;
                else if (r < 62) c = CMD_POLARITY;
                else if (r < 75) c = CMD_START;
                else if (r < 85) c = CMD_ON;
                else if (r < 89) c = CMD_STANDBY;
                else if (r < 92) c = CMD_SHUTDOWN;
                else             c = CMD_READ;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        // near the present current so ramps finish
                        near = int'(pred_current) + $urandom_range(0, 128) - 64;
                        if (near < 0) near = 0;
                        if (near > 65536) near = 65536;
                        sp = CUR_W'(near);
                    end
                    5, 6: sp = CUR_W'($urandom_range(0, 65536));
                    7: sp = $urandom_range(0, 1) ? 17'd65536 : 17'd0;
                    8: sp = CUR_W'($urandom);
                    default: sp = CUR_W'($urandom_range(65537, 131071));
                endcase
                send_item(c, sp, 2'($urandom));
                // hold off mid-phase until everything has drained
                if (k == per_phase / 2 && ph == 1) wait_idle();
            end
        end
    endtask

    initial begin
        pred_current = '0;
        pred_target  = '0;
        pred_pol     = 2'b00;
        pred_mode    = MODE_STANDBY;
        pred_armed   = 1'b0;
        step_up      = 17'd1;
        step_down    = 17'd1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_commands();
        test_step_extremes();
        test_random_traffic(6, 150);

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d items, checked %0d results over %0d step settings.",
                 n_sent, n_checked, n_step_settings);
        $display("Ramps run to completion: %0d; errors: %0d.", n_ramps_done, n_errors);
        if (n_errors == 0 && expected_readbacks.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[power_supply_current_ramp_top.f]
+incdir+design
design/pscr_pkg.sv
design/pscr_core.sv
design/power_supply_current_ramp_top.sv
tb/tb_power_supply_current_ramp_top.sv
